// ----- sv/dmpc_pkg.sv -----
// Shared constants, codes and control/status types for the direct-mapped page cache controller.
package dmpc_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int PAGE_W  = 32;
	localparam int ADDR_W  = 48;
	localparam int PSIZE_W = 21;
	localparam int OP_W    = 3;
	localparam int CMD_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam int PROD_W  = PSIZE_W + PAGE_W;
	localparam int SUM_W   = PROD_W + 1;

	localparam logic [OP_W-1:0] OP_READ       = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_WRITE = 3'd2;
	localparam logic [OP_W-1:0] OP_FLUSH      = 3'd3;
	localparam logic [OP_W-1:0] OP_NEW_PAGE   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT  = 2'd2;

	localparam logic [ADDR_W-1:0]  BASE_OFFSET_RST = '0;
	localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = 21'd4096;
	localparam logic [PAGE_W-1:0]  PAGE_COUNT_RST  = 32'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILL = 2'd0,
		CMD_WB   = 2'd1,
		CMD_HDR  = 2'd2,
		CMD_DONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic take_req;
		logic bump_counter;
		logic pop;
		logic load_sel_req;
		logic load_out;
		cmd_t out_kind;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic hit;
		logic slot_dirty;
		logic stack_empty;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- sv/dmpc_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
interface dmpc_req_if;
	logic valid;
	logic ready;
	logic [dmpc_pkg::OP_W-1:0] operation;
	logic [dmpc_pkg::PAGE_W-1:0] page_index;

	modport source (output valid, output operation, output page_index, input ready);
	modport sink (input valid, input operation, input page_index, output ready);
endinterface

interface dmpc_rsp_if;
	logic valid;
	logic ready;
	logic [dmpc_pkg::CMD_W-1:0] command;
	logic [dmpc_pkg::PAGE_W-1:0] result_page;
	logic [dmpc_pkg::SLOT_W-1:0] slot;
	logic [dmpc_pkg::ADDR_W-1:0] byte_address;
	logic last;

	modport source (output valid, output command, output result_page, output slot,
		output byte_address, output last, input ready);
	modport sink (input valid, input command, input result_page, input slot,
		input byte_address, input last, output ready);
endinterface

interface dmpc_cfg_if;
	logic valid;
	logic ready;
	logic [dmpc_pkg::CFG_IDX_W-1:0] index;
	logic [dmpc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/dmpc_ctrl.sv -----
// Request sequencer: plans write-backs, fills, header and done words and drives the datapath.
module dmpc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  dmpc_pkg::dp_stat_t stat,
	output dmpc_pkg::ctl_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOKUP = 6'b000010,
		S_NEXT   = 6'b000100,
		S_AW1    = 6'b001000,
		S_AW2    = 6'b010000,
		S_SEND   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic flush_pend_q, flush_pend_d;
	logic fill_pend_q, fill_pend_d;
	logic hdr_pend_q, hdr_pend_d;
	dmpc_pkg::cmd_t kind_q, kind_d;

	always_comb begin
		state_d      = state_q;
		flush_pend_d = flush_pend_q;
		fill_pend_d  = fill_pend_q;
		hdr_pend_d   = hdr_pend_q;
		kind_d       = kind_q;
		req_ready    = 1'b0;
		cmd          = '0;
		cmd.out_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take_req = 1'b1;
					state_d      = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				flush_pend_d = 1'b0;
				fill_pend_d  = 1'b0;
				hdr_pend_d   = 1'b0;
				state_d      = S_NEXT;
				unique case (stat.op)
					dmpc_pkg::OP_READ: begin
						fill_pend_d  = !stat.hit;
						flush_pend_d = !stat.hit && stat.slot_dirty;
					end
					dmpc_pkg::OP_WRITE: begin
						flush_pend_d = !stat.hit && stat.slot_dirty;
					end
					dmpc_pkg::OP_READ_WRITE: begin
						fill_pend_d  = !stat.hit;
						flush_pend_d = !stat.hit && stat.slot_dirty;
					end
					dmpc_pkg::OP_FLUSH: begin
						flush_pend_d = 1'b1;
					end
					dmpc_pkg::OP_NEW_PAGE: begin
						hdr_pend_d       = 1'b1;
						cmd.bump_counter = 1'b1;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_NEXT: begin
				if (flush_pend_q) begin
					if (stat.stack_empty) begin
						flush_pend_d = 1'b0;
					end else begin
						cmd.pop = 1'b1;
						kind_d  = dmpc_pkg::CMD_WB;
						state_d = S_AW1;
					end
				end else if (fill_pend_q) begin
					fill_pend_d      = 1'b0;
					cmd.load_sel_req = 1'b1;
					kind_d           = dmpc_pkg::CMD_FILL;
					state_d          = S_AW1;
				end else if (hdr_pend_q) begin
					hdr_pend_d = 1'b0;
					kind_d     = dmpc_pkg::CMD_HDR;
					state_d    = S_SEND;
				end else begin
					cmd.load_sel_req = 1'b1;
					kind_d           = dmpc_pkg::CMD_DONE;
					state_d          = S_AW1;
				end
			end
			S_AW1: begin
				state_d = S_AW2;
			end
			S_AW2: begin
				state_d = S_SEND;
			end
			S_SEND: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					if (kind_q == dmpc_pkg::CMD_DONE) begin
						cmd.commit = 1'b1;
						state_d    = S_IDLE;
					end else begin
						state_d = S_NEXT;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			flush_pend_q <= 1'b0;
			fill_pend_q  <= 1'b0;
			hdr_pend_q   <= 1'b0;
			kind_q       <= dmpc_pkg::CMD_DONE;
		end else begin
			state_q      <= state_d;
			flush_pend_q <= flush_pend_d;
			fill_pend_q  <= fill_pend_d;
			hdr_pend_q   <= hdr_pend_d;
			kind_q       <= kind_d;
		end
	end

endmodule

// ----- sv/dmpc_datapath.sv -----
// Tag, valid and dirty store, dirty stack, address pipeline and result register.
module dmpc_datapath (
	input  logic clk,
	input  logic arst_n,
	dmpc_cfg_if.sink cfg,
	input  logic [dmpc_pkg::OP_W-1:0] operation,
	input  logic [dmpc_pkg::PAGE_W-1:0] page_index,
	dmpc_rsp_if.source rsp,
	input  dmpc_pkg::ctl_cmd_t cmd,
	output dmpc_pkg::dp_stat_t stat
);

	logic [dmpc_pkg::OP_W-1:0]    op_q;
	logic [dmpc_pkg::PAGE_W-1:0]  page_q;
	logic [dmpc_pkg::PAGE_W-1:0]  sel_page_q;
	logic [dmpc_pkg::SLOT_W-1:0]  wb_slot_q;
	logic [dmpc_pkg::ADDR_W-1:0]  base_q;
	logic [dmpc_pkg::PSIZE_W-1:0] psize_q;
	logic [dmpc_pkg::PAGE_W-1:0]  counter_q;
	logic [dmpc_pkg::PAGE_W-1:0]  tag_q [dmpc_pkg::SLOTS];
	logic [dmpc_pkg::SLOT_W-1:0]  stack_q [dmpc_pkg::SLOTS];
	logic [dmpc_pkg::SLOTS-1:0]   valid_q;
	logic [dmpc_pkg::SLOTS-1:0]   dirty_q;
	logic [dmpc_pkg::CNT_W-1:0]   count_q;
	logic [dmpc_pkg::PROD_W-1:0]  prod_s1;
	logic [dmpc_pkg::ADDR_W-1:0]  addr_s2;

	logic                         out_valid_q;
	logic [dmpc_pkg::CMD_W-1:0]   out_cmd_q;
	logic [dmpc_pkg::PAGE_W-1:0]  out_page_q;
	logic [dmpc_pkg::SLOT_W-1:0]  out_slot_q;
	logic [dmpc_pkg::ADDR_W-1:0]  out_addr_q;
	logic                         out_last_q;

	logic [dmpc_pkg::SLOT_W-1:0]  req_slot;
	logic [dmpc_pkg::CNT_W-1:0]   count_dec;
	logic [dmpc_pkg::SLOT_W-1:0]  top_idx;
	logic [dmpc_pkg::SLOT_W-1:0]  tag_raddr;
	logic [dmpc_pkg::PAGE_W-1:0]  tag_rd;
	logic [dmpc_pkg::SUM_W-1:0]   addr_sum;
	logic                         is_rd;
	logic                         is_wr;
	logic                         push;
	logic                         cfg_wr;

	logic [dmpc_pkg::CMD_W-1:0]   nxt_cmd;
	logic [dmpc_pkg::PAGE_W-1:0]  nxt_page;
	logic [dmpc_pkg::SLOT_W-1:0]  nxt_slot;
	logic [dmpc_pkg::ADDR_W-1:0]  nxt_addr;

	assign req_slot  = page_q[dmpc_pkg::SLOT_W-1:0];
	assign count_dec = count_q - dmpc_pkg::CNT_W'(1);
	assign top_idx   = stack_q[count_dec[dmpc_pkg::SLOT_W-1:0]];
	assign tag_raddr = cmd.pop ? top_idx : req_slot;
	assign tag_rd    = tag_q[tag_raddr];
	assign is_rd     = (op_q == dmpc_pkg::OP_READ);
	assign is_wr     = (op_q == dmpc_pkg::OP_WRITE) || (op_q == dmpc_pkg::OP_READ_WRITE);
	assign push      = cmd.commit && is_wr && !dirty_q[req_slot]
		&& (count_q < dmpc_pkg::CNT_W'(dmpc_pkg::SLOTS));
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	assign stat.op          = op_q;
	assign stat.hit         = valid_q[req_slot] && (tag_rd == page_q);
	assign stat.slot_dirty  = dirty_q[req_slot];
	assign stat.stack_empty = (count_q == '0);
	assign stat.out_free    = !out_valid_q || rsp.ready;

	assign addr_sum = dmpc_pkg::SUM_W'(base_q) + dmpc_pkg::SUM_W'(prod_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= dmpc_pkg::PROD_W'(psize_q) * dmpc_pkg::PROD_W'(sel_page_q);
		addr_s2 <= (|addr_sum[dmpc_pkg::SUM_W-1:dmpc_pkg::ADDR_W]) ? '1
			: addr_sum[dmpc_pkg::ADDR_W-1:0];
	end

	always_comb begin
		nxt_cmd  = cmd.out_kind;
		nxt_page = page_q;
		nxt_slot = req_slot;
		nxt_addr = addr_s2;
		case (cmd.out_kind)
			dmpc_pkg::CMD_WB: begin
				nxt_page = sel_page_q;
				nxt_slot = wb_slot_q;
			end
			dmpc_pkg::CMD_HDR: begin
				nxt_page = counter_q;
				nxt_slot = '0;
				nxt_addr = base_q;
			end
			dmpc_pkg::CMD_DONE: begin
				if (op_q == dmpc_pkg::OP_FLUSH) begin
					nxt_page = '0;
					nxt_slot = '0;
					nxt_addr = '0;
				end else if (op_q == dmpc_pkg::OP_NEW_PAGE) begin
					nxt_slot = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= dmpc_pkg::BASE_OFFSET_RST;
			psize_q     <= dmpc_pkg::PAGE_SIZE_RST;
			counter_q   <= dmpc_pkg::PAGE_COUNT_RST;
			valid_q     <= '0;
			dirty_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg.index)
					dmpc_pkg::REG_BASE_OFFSET: base_q <= cfg.data[dmpc_pkg::ADDR_W-1:0];
					dmpc_pkg::REG_PAGE_SIZE:   psize_q <= cfg.data[dmpc_pkg::PSIZE_W-1:0];
					dmpc_pkg::REG_PAGE_COUNT:  counter_q <= cfg.data[dmpc_pkg::PAGE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.bump_counter) begin
				counter_q <= counter_q + dmpc_pkg::PAGE_W'(1);
			end
			if (cmd.pop) begin
				dirty_q[top_idx] <= 1'b0;
				count_q          <= count_dec;
			end
			if (cmd.commit && (is_rd || is_wr)) begin
				valid_q[req_slot] <= 1'b1;
				if (is_wr) begin
					dirty_q[req_slot] <= 1'b1;
				end
			end
			if (push) begin
				count_q <= count_q + dmpc_pkg::CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			op_q   <= operation;
			page_q <= page_index;
		end
		if (cmd.bump_counter) begin
			page_q <= counter_q;
		end
		if (cmd.load_sel_req) begin
			sel_page_q <= page_q;
		end
		if (cmd.pop) begin
			sel_page_q <= tag_rd;
			wb_slot_q  <= top_idx;
		end
		if (cmd.commit && (is_rd || is_wr)) begin
			tag_q[req_slot] <= page_q;
		end
		if (push) begin
			stack_q[count_q[dmpc_pkg::SLOT_W-1:0]] <= req_slot;
		end
		if (cmd.load_out) begin
			out_cmd_q  <= nxt_cmd;
			out_page_q <= nxt_page;
			out_slot_q <= nxt_slot;
			out_addr_q <= nxt_addr;
			out_last_q <= (cmd.out_kind == dmpc_pkg::CMD_DONE);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.command      = out_cmd_q;
	assign rsp.result_page  = out_page_q;
	assign rsp.slot         = out_slot_q;
	assign rsp.byte_address = out_addr_q;
	assign rsp.last         = out_last_q;

endmodule

// ----- sv/direct_mapped_page_cache_controller.sv -----
// Top level of the direct-mapped write-back page cache controller.
// Requests arrive on req (operation, page_index), one word per request. For each request
// the block sends a sequence of words on rsp: write-backs of every dirty page (most
// recently first-dirtied first) when a slot must be reused or on flush, a fill on a
// read or read-write miss, a header write on a page allocation, then a done word with last.
// Codes 5 to 7 are dropped with no result. The user must write registers on cfg (index,
// data) only while the block is idle; the block does not enforce it. cfg is always ready.
// One request is handled at a time; req is ready only when the sequencer is idle.
// Every write-back and every fill passes through the sequencer states NEXT, AW1, AW2 and
// SEND, and a walk of the dirty stack ends with a last visit to NEXT that finds it empty.
// Each write-back, fill and done word waits in AW1 and AW2 for the page-size multiply and
// the saturating add.
// The next request is taken while the last done word still waits in the output register.
// A stalled receiver holds the output register; the sequencer waits until it frees.
// Reset clears the valid and dirty bits and the dirty stack and loads the register
// reset values; the page counter restarts from the initial page count.
module direct_mapped_page_cache_controller (
	input  logic clk,
	input  logic arst_n,
	dmpc_cfg_if.sink cfg,
	dmpc_req_if.sink req,
	dmpc_rsp_if.source rsp
);

	dmpc_pkg::ctl_cmd_t cmd;
	dmpc_pkg::dp_stat_t stat;
	logic ready;

	assign req.ready = ready;

	dmpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dmpc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.operation  (req.operation),
		.page_index (req.page_index),
		.rsp        (rsp),
		.cmd        (cmd),
		.stat       (stat)
	);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result register loaded while occupied");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken while one is in progress");

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.last == (rsp.command == dmpc_pkg::CMD_DONE)))
		else $error("last flag does not match done word");

	a_header_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.command == dmpc_pkg::CMD_HDR |-> rsp.slot == '0)
		else $error("header word with nonzero slot");

endmodule

// ----- bench/direct_mapped_page_cache_controller_tb.sv -----
// Self-checking bench for the page cache controller: predicted command words against rsp.
module direct_mapped_page_cache_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ADDR_LIMIT = (64'd1 << dmpc_pkg::ADDR_W) - 64'd1;
	localparam int IDLE_PCT = 14;
	localparam int HOLDOFF_AT = 60;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int STEADY_FROM = 260;
	localparam int STEADY_TO = 360;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 30;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [dmpc_pkg::OP_W-1:0] op;
		logic [dmpc_pkg::PAGE_W-1:0] page;
	} page_request_t;

	typedef struct packed {
		dmpc_pkg::cmd_t command;
		logic [dmpc_pkg::PAGE_W-1:0] page;
		logic [dmpc_pkg::SLOT_W-1:0] slot;
		logic [dmpc_pkg::ADDR_W-1:0] addr;
		logic last;
	} store_word_t;

	logic clk;
	logic arst_n;

	dmpc_cfg_if cfg_ch ();
	dmpc_req_if req_ch ();
	dmpc_rsp_if rsp_ch ();

	direct_mapped_page_cache_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [dmpc_pkg::ADDR_W-1:0] base_reg = dmpc_pkg::BASE_OFFSET_RST;
	logic [dmpc_pkg::PSIZE_W-1:0] psize_reg = dmpc_pkg::PAGE_SIZE_RST;
	logic [dmpc_pkg::PAGE_W-1:0] page_counter = dmpc_pkg::PAGE_COUNT_RST;
	logic [dmpc_pkg::PAGE_W-1:0] line_tag [dmpc_pkg::SLOTS] = '{default: '0};
	logic line_valid [dmpc_pkg::SLOTS] = '{default: 1'b0};
	logic line_dirty [dmpc_pkg::SLOTS] = '{default: 1'b0};
	logic [dmpc_pkg::SLOT_W-1:0] dirty_order [dmpc_pkg::SLOTS] = '{default: '0};
	int dirty_depth = 0;

	page_request_t pending_requests[$];
	store_word_t expected_words[$];

	int requests_taken = 0;
	int planned_items = 0;
	int dropped_codes = 0;
	int words_checked = 0;
	int words_this_req = 0;
	int longest_answer = 0;
	int saturated_addrs = 0;
	int settings_used = 0;
	int mismatches = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;
	logic steady;

	assign steady = (requests_taken >= STEADY_FROM) && (requests_taken < STEADY_TO);

	function automatic logic [dmpc_pkg::ADDR_W-1:0] page_address(
		input logic [dmpc_pkg::PAGE_W-1:0] page);
		logic [63:0] full;
		full = 64'(base_reg) + 64'(psize_reg) * 64'(page);
		if (full > ADDR_LIMIT) begin
			saturated_addrs++;
			return ADDR_LIMIT[dmpc_pkg::ADDR_W-1:0];
		end
		return full[dmpc_pkg::ADDR_W-1:0];
	endfunction

	task automatic queue_word(input dmpc_pkg::cmd_t command,
		input logic [dmpc_pkg::PAGE_W-1:0] page, input logic [dmpc_pkg::SLOT_W-1:0] slot,
		input logic [dmpc_pkg::ADDR_W-1:0] addr, input logic last);
		store_word_t w;
		w.command = command;
		w.page = page;
		w.slot = slot;
		w.addr = addr;
		w.last = last;
		expected_words.push_back(w);
		words_this_req++;
	endtask

	task automatic write_back_all();
		logic [dmpc_pkg::SLOT_W-1:0] s;
		while (dirty_depth > 0) begin
			dirty_depth--;
			s = dirty_order[dirty_depth];
			queue_word(dmpc_pkg::CMD_WB, line_tag[s], s, page_address(line_tag[s]), 1'b0);
			line_dirty[s] = 1'b0;
		end
	endtask

	task automatic predict_request(input logic [dmpc_pkg::OP_W-1:0] op,
		input logic [dmpc_pkg::PAGE_W-1:0] page);
		logic [dmpc_pkg::SLOT_W-1:0] s;
		logic hit;
		logic [dmpc_pkg::PAGE_W-1:0] fresh;
		s = page[dmpc_pkg::SLOT_W-1:0];
		hit = line_valid[s] && (line_tag[s] == page);
		words_this_req = 0;
		case (op)
			dmpc_pkg::OP_READ: begin
				if (!hit) begin
					if (line_dirty[s])
						write_back_all();
					queue_word(dmpc_pkg::CMD_FILL, page, s, page_address(page), 1'b0);
					line_tag[s] = page;
					line_valid[s] = 1'b1;
				end
				queue_word(dmpc_pkg::CMD_DONE, page, s, page_address(page), 1'b1);
			end
			dmpc_pkg::OP_WRITE, dmpc_pkg::OP_READ_WRITE: begin
				if (!hit && line_dirty[s])
					write_back_all();
				if (!line_dirty[s] && dirty_depth < dmpc_pkg::SLOTS) begin
					dirty_order[dirty_depth] = s;
					dirty_depth++;
				end
				if (op == dmpc_pkg::OP_READ_WRITE && !hit)
					queue_word(dmpc_pkg::CMD_FILL, page, s, page_address(page), 1'b0);
				line_tag[s] = page;
				line_valid[s] = 1'b1;
				line_dirty[s] = 1'b1;
				queue_word(dmpc_pkg::CMD_DONE, page, s, page_address(page), 1'b1);
			end
			dmpc_pkg::OP_FLUSH: begin
				write_back_all();
				queue_word(dmpc_pkg::CMD_DONE, '0, '0, '0, 1'b1);
			end
			dmpc_pkg::OP_NEW_PAGE: begin
				fresh = page_counter;
				page_counter = page_counter + dmpc_pkg::PAGE_W'(1);
				queue_word(dmpc_pkg::CMD_HDR, page_counter, '0, base_reg, 1'b0);
				queue_word(dmpc_pkg::CMD_DONE, fresh, '0, page_address(fresh), 1'b1);
			end
			default: dropped_codes++;
		endcase
		if (words_this_req > longest_answer)
			longest_answer = words_this_req;
	endtask

	task automatic add_request(input logic [dmpc_pkg::OP_W-1:0] op,
		input logic [dmpc_pkg::PAGE_W-1:0] page);
		page_request_t r;
		r.op = op;
		r.page = page;
		pending_requests.push_back(r);
		if (op <= dmpc_pkg::OP_NEW_PAGE)
			planned_items++;
	endtask

	task automatic write_reg(input logic [dmpc_pkg::CFG_IDX_W-1:0] idx,
		input logic [dmpc_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			dmpc_pkg::REG_BASE_OFFSET: base_reg = value[dmpc_pkg::ADDR_W-1:0];
			dmpc_pkg::REG_PAGE_SIZE: psize_reg = value[dmpc_pkg::PSIZE_W-1:0];
			dmpc_pkg::REG_PAGE_COUNT: page_counter = value[dmpc_pkg::PAGE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_setting(input logic [dmpc_pkg::ADDR_W-1:0] base,
		input logic [dmpc_pkg::PSIZE_W-1:0] psize, input logic [dmpc_pkg::PAGE_W-1:0] count);
		write_reg(dmpc_pkg::REG_BASE_OFFSET, dmpc_pkg::CFG_DATA_W'(base));
		write_reg(dmpc_pkg::REG_PAGE_SIZE, dmpc_pkg::CFG_DATA_W'(psize));
		write_reg(dmpc_pkg::REG_PAGE_COUNT, dmpc_pkg::CFG_DATA_W'(count));
		settings_used++;
		@(negedge clk);
	endtask

	task automatic drain_block();
		do @(negedge clk);
		while (pending_requests.size() != 0 || req_ch.valid || expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int target);
		logic [dmpc_pkg::PAGE_W-1:0] tags [4];
		logic [dmpc_pkg::PAGE_W-1:0] page;
		logic [dmpc_pkg::OP_W-1:0] op;
		int start, pick, k;
		for (k = 0; k < 4; k++)
			tags[k] = $urandom();
		start = planned_items;
		while (planned_items - start < target) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				// dirty every slot, then force a conflict that writes them all back
				for (k = 0; k < dmpc_pkg::SLOTS; k++)
					add_request($urandom_range(1) ? dmpc_pkg::OP_WRITE : dmpc_pkg::OP_READ_WRITE,
						{tags[0][dmpc_pkg::PAGE_W-1:dmpc_pkg::SLOT_W], dmpc_pkg::SLOT_W'(k)});
				add_request($urandom_range(1) ? dmpc_pkg::OP_READ : dmpc_pkg::OP_READ_WRITE,
					{tags[1][dmpc_pkg::PAGE_W-1:dmpc_pkg::SLOT_W],
					dmpc_pkg::SLOT_W'($urandom_range(dmpc_pkg::SLOTS-1))});
			end else if (pick < 12) begin
				add_request(dmpc_pkg::OP_W'($urandom_range(7)), $urandom());
			end else begin
				pick = $urandom_range(99);
				if (pick < 32)
					op = dmpc_pkg::OP_READ;
				else if (pick < 57)
					op = dmpc_pkg::OP_WRITE;
				else if (pick < 77)
					op = dmpc_pkg::OP_READ_WRITE;
				else if (pick < 88)
					op = dmpc_pkg::OP_FLUSH;
				else
					op = dmpc_pkg::OP_NEW_PAGE;
				if ($urandom_range(99) < 85)
					page = {tags[$urandom_range(3)][dmpc_pkg::PAGE_W-1:dmpc_pkg::SLOT_W],
						dmpc_pkg::SLOT_W'($urandom_range(dmpc_pkg::SLOTS-1))};
				else
					page = $urandom();
				add_request(op, page);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("direct_mapped_page_cache_controller test failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= dmpc_pkg::OP_READ;
			req_ch.page_index <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_request(req_ch.operation, req_ch.page_index);
				requests_taken <= requests_taken + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					req_ch.valid <= 1'b1;
					req_ch.operation <= pending_requests[0].op;
					req_ch.page_index <= pending_requests[0].page;
					void'(pending_requests.pop_front());
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (!holdoff_done && requests_taken >= HOLDOFF_AT) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		store_word_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected word: cmd %0d page %h slot %0d addr %h last %0d",
							rsp_ch.command, rsp_ch.result_page, rsp_ch.slot,
							rsp_ch.byte_address, rsp_ch.last);
				end else begin
					want = expected_words.pop_front();
					if (rsp_ch.command !== want.command || rsp_ch.result_page !== want.page ||
						rsp_ch.slot !== want.slot || rsp_ch.byte_address !== want.addr ||
						rsp_ch.last !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"word %0d mismatch: exp cmd %0d page %h slot %0d addr %h ",
								"last %0d, got cmd %0d page %h slot %0d addr %h last %0d"},
								words_checked, want.command, want.page, want.slot, want.addr,
								want.last, rsp_ch.command, rsp_ch.result_page, rsp_ch.slot,
								rsp_ch.byte_address, rsp_ch.last);
					end
				end
			end
			// hold off once to back the block up into its input
			if (holdoff_left > 0 || (!holdoff_done && requests_taken >= HOLDOFF_AT)) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = dmpc_pkg::REG_BASE_OFFSET;
		cfg_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		settings_used = 1;
		repeat (4) @(negedge clk);

		add_request(dmpc_pkg::OP_READ, 32'h0000_0000);
		add_request(dmpc_pkg::OP_READ, 32'h0000_0000);
		add_request(dmpc_pkg::OP_WRITE, 32'h0000_0000);
		add_request(dmpc_pkg::OP_WRITE, 32'h0000_0010);
		add_request(dmpc_pkg::OP_READ_WRITE, 32'hFFFF_FFFF);
		add_request(dmpc_pkg::OP_READ_WRITE, 32'hFFFF_FFFF);
		add_request(dmpc_pkg::OP_WRITE, 32'h0000_0001);
		add_request(dmpc_pkg::OP_WRITE, 32'h0000_0002);
		add_request(dmpc_pkg::OP_READ, 32'h0000_0011);
		add_request(dmpc_pkg::OP_WRITE, 32'h0000_0005);
		add_request(dmpc_pkg::OP_READ_WRITE, 32'h0000_0015);
		add_request(dmpc_pkg::OP_FLUSH, 32'hFFFF_FFFF);
		add_request(dmpc_pkg::OP_FLUSH, 32'h0000_0000);
		add_request(dmpc_pkg::OP_NEW_PAGE, 32'h1234_5678);
		add_request(dmpc_pkg::OP_NEW_PAGE, 32'hFFFF_FFFF);
		add_request(dmpc_pkg::OP_W'(5), 32'hFFFF_FFFF);
		add_request(dmpc_pkg::OP_W'(6), 32'h0000_0000);
		add_request(dmpc_pkg::OP_W'(7), 32'hA5A5_A5A5);
		add_request(dmpc_pkg::OP_READ, 32'hFFFF_FFF0);
		add_request(dmpc_pkg::OP_WRITE, 32'h8000_0000);
		add_request(dmpc_pkg::OP_READ, 32'h7FFF_FFFF);
		add_request(dmpc_pkg::OP_READ, 32'hFFFF_FFFF);
		drain_block();

		program_setting('0, dmpc_pkg::PSIZE_W'(64), 32'd1);
		random_phase(100);
		drain_block();

		program_setting({dmpc_pkg::ADDR_W{1'b1}}, dmpc_pkg::PSIZE_W'(1048576), 32'hFFFF_FFFF);
		random_phase(100);
		drain_block();

		program_setting(dmpc_pkg::ADDR_W'({$urandom(), $urandom()}),
			dmpc_pkg::PSIZE_W'($urandom_range(1048576, 64)), ($urandom() | 32'd1));
		random_phase(120);
		drain_block();

		program_setting(dmpc_pkg::ADDR_W'(48'h0000_1000_0000),
			dmpc_pkg::PSIZE_W'($urandom_range(4096, 64)), 32'hFFFF_FFFE);
		random_phase(120);
		drain_block();

		repeat (TAIL_CYCLES) @(negedge clk);
		mismatches += expected_words.size();
		$display("Covered %0d requests (%0d dropped codes) over %0d register settings.",
			requests_taken, dropped_codes, settings_used);
		$display("Checked %0d words, longest answer %0d words, %0d saturated addresses.",
			words_checked, longest_answer, saturated_addrs);
		if (mismatches == 0) begin
			$display("direct_mapped_page_cache_controller test passed");
		end else begin
			$display("direct_mapped_page_cache_controller test failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/dmpc_pkg.sv
sv/dmpc_if.sv
sv/dmpc_ctrl.sv
sv/dmpc_datapath.sv
sv/direct_mapped_page_cache_controller.sv
bench/direct_mapped_page_cache_controller_tb.sv
